// ----- design/hex_record_lexer_assert.svh -----
// Assertion macros used by the hex record lexer RTL.
`ifndef HEX_RECORD_LEXER_ASSERT_SVH
`define HEX_RECORD_LEXER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define HRL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/hrl_pkg.sv -----
// Types, character codes and helpers for the hex record lexer.
package hrl_pkg;

	typedef enum logic [2:0] {
		PH_COLON = 3'd0,
		PH_LEN   = 3'd1,
		PH_OFS   = 3'd2,
		PH_TYPE  = 3'd3,
		PH_DATA  = 3'd4,
		PH_SUM   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		TK_MARK = 3'd0,
		TK_LEN  = 3'd1,
		TK_OFS  = 3'd2,
		TK_TYPE = 3'd3,
		TK_DATA = 3'd4,
		TK_SUM  = 3'd5
	} kind_t;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF_HEX = 8'h66;
	localparam logic [7:0] TYPE_EOF   = 8'h01;

	localparam int unsigned NIB_W   = 4;
	localparam int unsigned DIGIT_W = 9;

	// Decoded hex digit: bad set when the character is not a hex digit.
	typedef struct packed {
		logic             bad;
		logic [NIB_W-1:0] val;
	} nibble_t;

	function automatic nibble_t hex_nibble(input logic [7:0] c);
		nibble_t r;
		logic [7:0] d;
		r.bad = 1'b0;
		d = 8'h00;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			d = c - CHAR_0;
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			d = c - CHAR_UA + 8'd10;
		end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
			d = c - CHAR_LA + 8'd10;
		end else begin
			r.bad = 1'b1;
		end
		r.val = d[NIB_W-1:0];
		return r;
	endfunction

	// Replace the high (hi = 1) or low nibble of a byte.
	function automatic logic [7:0] put_byte_nibble(input logic [7:0] b,
			input logic [NIB_W-1:0] n, input logic hi);
		logic [7:0] r;
		r = hi ? {n, b[3:0]} : {b[7:4], n};
		return r;
	endfunction

	// Replace nibble pos (0 = lowest) of a 16-bit word.
	function automatic logic [15:0] put_word_nibble(input logic [15:0] w,
			input logic [NIB_W-1:0] n, input logic [1:0] pos);
		logic [15:0] r;
		r = w;
		case (pos)
			2'd0: r[3:0]   = n;
			2'd1: r[7:4]   = n;
			2'd2: r[11:8]  = n;
			2'd3: r[15:12] = n;
			default: r = w;
		endcase
		return r;
	endfunction

endpackage

// ----- design/hex_record_lexer.sv -----
// Hex record lexer: splits a hex record text stream into tokens.
//
// Usage:
//  - Input stream s_axis: one ASCII character per transfer in tdata[7:0].
//  - Output stream m_axis: exactly one result transfer per input character.
//    tdata carries status, token_valid, token_value and end_of_file_seen;
//    tuser carries token_kind (mark, length, offset, type, data byte, sum).
//  - A colon opens a record; the byte count, load offset, record type, each
//    data byte and the checksum come out as tokens on the digit that ends
//    them. CR/LF pass silently; other non-hex characters report status 1
//    and leave the parser untouched. The checksum is not verified.
//  - The result of a character is registered and is on m_axis the cycle after
//    its transfer. One character per cycle while m_axis_tready is high, set by
//    the single output register; decode and field update are combinational.
//  - Stall: when m_axis_tready is low, the held result stays put and the
//    input side stops taking characters until the result is taken; the
//    input is accepted in the same cycle the held result drains.
//  - Reset (arst_n low): the parser returns to waiting for a colon, all
//    record fields clear and the output register empties.
`include "hex_record_lexer_assert.svh"

module hex_record_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] character
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [0] status, [1] token_valid,
	                                    // [17:2] token_value,
	                                    // [18] end_of_file_seen, [23:19] zero
	output logic [2:0]  m_axis_tuser    // [2:0] token_kind
);

	// Parser state
	hrl_pkg::phase_t                 phase_q, phase_d;
	logic [hrl_pkg::DIGIT_W-1:0]     digits_q, digits_d;
	logic [7:0]                      len_q, len_d;
	logic [15:0]                     ofs_q, ofs_d;
	logic [7:0]                      type_q, type_d;
	logic [7:0]                      data_q, data_d;
	logic [7:0]                      sum_q, sum_d;
	logic                            eof_q, eof_d;

	// Result register
	logic                            out_valid_q;
	logic                            status_q, tok_valid_q, eof_out_q;
	logic [2:0]                      kind_q;
	logic [15:0]                     value_q;

	// Combinational result
	logic                            status_d, tok_valid_d;
	hrl_pkg::kind_t                  kind_d;
	logic [15:0]                     value_d;

	hrl_pkg::nibble_t                nib;
	logic                            is_colon, is_break, in_record;
	logic [hrl_pkg::DIGIT_W-1:0]     dl;
	logic [7:0]                      byte_new;
	logic [15:0]                     word_new;
	logic                            s_fire;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	assign nib       = hrl_pkg::hex_nibble(s_axis_tdata);
	assign is_colon  = (s_axis_tdata == hrl_pkg::CHAR_COLON);
	assign is_break  = (s_axis_tdata == hrl_pkg::CHAR_LF) ||
	                   (s_axis_tdata == hrl_pkg::CHAR_CR);
	assign in_record = (phase_q == hrl_pkg::PH_LEN)  || (phase_q == hrl_pkg::PH_OFS) ||
	                   (phase_q == hrl_pkg::PH_TYPE) || (phase_q == hrl_pkg::PH_DATA) ||
	                   (phase_q == hrl_pkg::PH_SUM);
	assign dl        = digits_q - {{(hrl_pkg::DIGIT_W-1){1'b0}}, 1'b1};

	// Next state and token for the character at the input
	always_comb begin
		phase_d     = phase_q;
		digits_d    = digits_q;
		len_d       = len_q;
		ofs_d       = ofs_q;
		type_d      = type_q;
		data_d      = data_q;
		sum_d       = sum_q;
		eof_d       = eof_q;
		status_d    = 1'b0;
		tok_valid_d = 1'b0;
		kind_d      = hrl_pkg::TK_MARK;
		value_d     = 16'h0000;
		byte_new    = 8'h00;
		word_new    = 16'h0000;
		if (is_break) begin
			// line breaks are skipped
		end else if (!is_colon && nib.bad) begin
			status_d = 1'b1;
		end else if (!in_record) begin
			if (is_colon) begin
				len_d       = 8'h00;
				ofs_d       = 16'h0000;
				type_d      = 8'h00;
				data_d      = 8'h00;
				sum_d       = 8'h00;
				eof_d       = 1'b0;
				tok_valid_d = 1'b1;
				kind_d      = hrl_pkg::TK_MARK;
				value_d     = {8'h00, hrl_pkg::CHAR_COLON};
				phase_d     = hrl_pkg::PH_LEN;
				digits_d    = hrl_pkg::DIGIT_W'(2);
			end
		end else if (nib.bad) begin
			// colon inside a record
			status_d = 1'b1;
		end else begin
			digits_d = dl;
			case (phase_q)
				hrl_pkg::PH_LEN: begin
					byte_new = hrl_pkg::put_byte_nibble(len_q, nib.val, dl[0]);
					len_d    = byte_new;
					if (dl == '0) begin
						tok_valid_d = 1'b1;
						kind_d      = hrl_pkg::TK_LEN;
						value_d     = {8'h00, byte_new};
						phase_d     = hrl_pkg::PH_OFS;
						digits_d    = hrl_pkg::DIGIT_W'(4);
					end
				end
				hrl_pkg::PH_OFS: begin
					word_new = hrl_pkg::put_word_nibble(ofs_q, nib.val, dl[1:0]);
					ofs_d    = word_new;
					if (dl == '0) begin
						tok_valid_d = 1'b1;
						kind_d      = hrl_pkg::TK_OFS;
						value_d     = word_new;
						phase_d     = hrl_pkg::PH_TYPE;
						digits_d    = hrl_pkg::DIGIT_W'(2);
					end
				end
				hrl_pkg::PH_TYPE: begin
					byte_new = hrl_pkg::put_byte_nibble(type_q, nib.val, dl[0]);
					type_d   = byte_new;
					if (dl == '0) begin
						tok_valid_d = 1'b1;
						kind_d      = hrl_pkg::TK_TYPE;
						value_d     = {8'h00, byte_new};
						if (byte_new == hrl_pkg::TYPE_EOF) begin
							eof_d = 1'b1;
						end
						data_d = 8'h00;
						if (len_q != 8'h00) begin
							phase_d  = hrl_pkg::PH_DATA;
							digits_d = {len_q, 1'b0};
						end else begin
							phase_d  = hrl_pkg::PH_SUM;
							digits_d = hrl_pkg::DIGIT_W'(2);
						end
					end
				end
				hrl_pkg::PH_DATA: begin
					byte_new = hrl_pkg::put_byte_nibble(data_q, nib.val, dl[0]);
					data_d   = byte_new;
					if (!dl[0]) begin
						tok_valid_d = 1'b1;
						kind_d      = hrl_pkg::TK_DATA;
						value_d     = {8'h00, byte_new};
						data_d      = 8'h00;
					end
					if (dl == '0) begin
						phase_d  = hrl_pkg::PH_SUM;
						digits_d = hrl_pkg::DIGIT_W'(2);
					end
				end
				default: begin
					// checksum phase
					byte_new = hrl_pkg::put_byte_nibble(sum_q, nib.val, dl[0]);
					sum_d    = byte_new;
					if (dl == '0) begin
						tok_valid_d = 1'b1;
						kind_d      = hrl_pkg::TK_SUM;
						value_d     = {8'h00, byte_new};
						phase_d     = hrl_pkg::PH_COLON;
					end
				end
			endcase
		end
	end

	// Parser state moves on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hrl_pkg::PH_COLON;
			digits_q <= '0;
			len_q    <= 8'h00;
			ofs_q    <= 16'h0000;
			type_q   <= 8'h00;
			data_q   <= 8'h00;
			sum_q    <= 8'h00;
			eof_q    <= 1'b0;
		end else if (s_fire) begin
			phase_q  <= phase_d;
			digits_q <= digits_d;
			len_q    <= len_d;
			ofs_q    <= ofs_d;
			type_q   <= type_d;
			data_q   <= data_d;
			sum_q    <= sum_d;
			eof_q    <= eof_d;
		end
	end

	// Output register: loads on input transfer, drains on output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			status_q    <= status_d;
			tok_valid_q <= tok_valid_d;
			kind_q      <= kind_d;
			value_q     <= value_d;
			eof_out_q   <= eof_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, eof_out_q, value_q, tok_valid_q, status_q};
	assign m_axis_tuser  = kind_q;

	// Checks
	`HRL_ASSERT_IMP(a_idle_token_zero, clk, arst_n,
		out_valid_q && !tok_valid_q, (kind_q == hrl_pkg::TK_MARK) && (value_q == 16'h0000),
		"token kind/value set without a token")
	`HRL_ASSERT_IMP(a_status_no_token, clk, arst_n,
		out_valid_q && status_q, !tok_valid_q,
		"invalid character produced a token")
	`HRL_ASSERT_NXT(a_colon_opens, clk, arst_n,
		s_fire && is_colon && (phase_q == hrl_pkg::PH_COLON),
		(phase_q == hrl_pkg::PH_LEN) && (digits_q == hrl_pkg::DIGIT_W'(2)) && tok_valid_q,
		"colon did not open a record")
	`HRL_ASSERT_IMP(a_record_has_digits, clk, arst_n,
		in_record, digits_q != '0,
		"record phase with no digits left")

endmodule

// ----- tb/hex_record_lexer_tb.sv -----
// Self-checking testbench for the hex record lexer: stray characters, records, noise.
`timescale 1ns / 1ps

module hex_record_lexer_tb;

	localparam int ITEM_TARGET = 1950;
	localparam int CYCLE_LIMIT = 400000;

	// One lexer result as it should appear on m_axis.
	typedef struct {
		logic           status;
		logic           tok_valid;
		hrl_pkg::kind_t kind;
		logic [15:0]    value;
		logic           eof;
	} token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] character
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;           // [0] status, [1] token_valid, [17:2] token_value,
	                                     // [18] end_of_file_seen, [23:19] zero
	logic [2:0]  m_axis_tuser;           // [2:0] token_kind

	// Mirror of the lexer state.
	hrl_pkg::phase_t lex_phase = hrl_pkg::PH_COLON;
	logic [8:0]  lex_digits = '0;
	logic [7:0]  lex_len = '0;
	logic [15:0] lex_ofs = '0;
	logic [7:0]  lex_type = '0;
	logic [7:0]  lex_data = '0;
	logic [7:0]  lex_sum = '0;
	logic        lex_eof = 1'b0;

	token_t expected_tokens[$];
	int     sent_count = 0;
	int     fail_count = 0;
	int     cycle_count = 0;
	int     rx_hold = 0;
	bit     no_gaps = 1'b0;
	int     big_records_left = 2;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hex_record_lexer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// [4] set when not a hex digit, [3:0] digit value.
	function automatic logic [4:0] decode_digit(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= hrl_pkg::CHAR_0 && c <= hrl_pkg::CHAR_9) begin
			d = c - hrl_pkg::CHAR_0;
		end else if (c >= hrl_pkg::CHAR_UA && c <= hrl_pkg::CHAR_UF) begin
			d = c - hrl_pkg::CHAR_UA + 8'd10;
		end else if (c >= hrl_pkg::CHAR_LA && c <= hrl_pkg::CHAR_LF_HEX) begin
			d = c - hrl_pkg::CHAR_LA + 8'd10;
		end else begin
			return 5'h10;
		end
		return {1'b0, d[3:0]};
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] nib, input bit upper);
		if (nib < 4'd10) begin
			return hrl_pkg::CHAR_0 + {4'h0, nib};
		end
		return (upper ? hrl_pkg::CHAR_UA : hrl_pkg::CHAR_LA) + {4'h0, nib} - 8'd10;
	endfunction

	// Random character that is neither a hex digit, a colon nor a line break.
	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		logic [4:0] dig;
		do begin
			c = 8'($urandom_range(0, 255));
			dig = decode_digit(c);
		end while (!dig[4] || c == hrl_pkg::CHAR_COLON || c == hrl_pkg::CHAR_CR ||
			c == hrl_pkg::CHAR_LF);
		return c;
	endfunction

	// Advance the mirrored lexer by one character and queue the result it gives.
	task automatic lex_char(input logic [7:0] c);
		token_t     tok;
		logic [4:0] dig;
		logic [8:0] pos;
		tok = '{status: 1'b0, tok_valid: 1'b0, kind: hrl_pkg::TK_MARK, value: 16'h0,
			eof: 1'b0};
		dig = decode_digit(c);
		if (c == hrl_pkg::CHAR_LF || c == hrl_pkg::CHAR_CR) begin
			// line breaks pass silently
		end else if (c != hrl_pkg::CHAR_COLON && dig[4]) begin
			tok.status = 1'b1;
		end else if (lex_phase == hrl_pkg::PH_COLON) begin
			// digits outside a record are dropped; a colon opens one
			if (c == hrl_pkg::CHAR_COLON) begin
				lex_len = '0;
				lex_ofs = '0;
				lex_type = '0;
				lex_data = '0;
				lex_sum = '0;
				lex_eof = 1'b0;
				tok.tok_valid = 1'b1;
				tok.kind = hrl_pkg::TK_MARK;
				tok.value = {8'h00, hrl_pkg::CHAR_COLON};
				lex_phase = hrl_pkg::PH_LEN;
				lex_digits = 9'd2;
			end
		end else if (dig[4]) begin
			tok.status = 1'b1;  // colon inside a record
		end else begin
			lex_digits = lex_digits - 9'd1;
			pos = lex_digits;
			case (lex_phase)
				hrl_pkg::PH_LEN: begin
					lex_len[pos[0]*4 +: 4] = dig[3:0];
					if (lex_digits == 0) begin
						tok.tok_valid = 1'b1;
						tok.kind = hrl_pkg::TK_LEN;
						tok.value = {8'h00, lex_len};
						lex_phase = hrl_pkg::PH_OFS;
						lex_digits = 9'd4;
					end
				end
				hrl_pkg::PH_OFS: begin
					lex_ofs[pos[1:0]*4 +: 4] = dig[3:0];
					if (lex_digits == 0) begin
						tok.tok_valid = 1'b1;
						tok.kind = hrl_pkg::TK_OFS;
						tok.value = lex_ofs;
						lex_phase = hrl_pkg::PH_TYPE;
						lex_digits = 9'd2;
					end
				end
				hrl_pkg::PH_TYPE: begin
					lex_type[pos[0]*4 +: 4] = dig[3:0];
					if (lex_digits == 0) begin
						tok.tok_valid = 1'b1;
						tok.kind = hrl_pkg::TK_TYPE;
						tok.value = {8'h00, lex_type};
						if (lex_type == hrl_pkg::TYPE_EOF) lex_eof = 1'b1;
						lex_data = '0;
						if (lex_len != 0) begin
							lex_phase = hrl_pkg::PH_DATA;
							lex_digits = {lex_len, 1'b0};
						end else begin
							lex_phase = hrl_pkg::PH_SUM;
							lex_digits = 9'd2;
						end
					end
				end
				hrl_pkg::PH_DATA: begin
					lex_data[pos[0]*4 +: 4] = dig[3:0];
					if (!pos[0]) begin
						tok.tok_valid = 1'b1;
						tok.kind = hrl_pkg::TK_DATA;
						tok.value = {8'h00, lex_data};
						lex_data = '0;
					end
					if (lex_digits == 0) begin
						lex_phase = hrl_pkg::PH_SUM;
						lex_digits = 9'd2;
					end
				end
				default: begin
					lex_sum[pos[0]*4 +: 4] = dig[3:0];
					if (lex_digits == 0) begin
						tok.tok_valid = 1'b1;
						tok.kind = hrl_pkg::TK_SUM;
						tok.value = {8'h00, lex_sum};
						lex_phase = hrl_pkg::PH_COLON;
					end
				end
			endcase
		end
		tok.eof = lex_eof;
		expected_tokens.push_back(tok);
	endtask

	// One character transfer on s_axis, after a random gap.
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		lex_char(c);
		sent_count++;
	endtask

	// Value as hex text, high digit first, each digit in random case.
	task automatic send_hex(input logic [15:0] val, input int ndigits);
		for (int i = ndigits - 1; i >= 0; i--) begin
			send_char(digit_char(val[i*4 +: 4], 1'($urandom_range(0, 1))));
		end
	endtask

	// Full record; with noise, stray characters get mixed in among the digits.
	task automatic send_record(input logic [7:0] len, input logic [15:0] ofs,
			input logic [7:0] rtype, input bit noisy, input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] b;
		sum = len + ofs[15:8] + ofs[7:0] + rtype;
		send_char(hrl_pkg::CHAR_COLON);
		send_hex({8'h00, len}, 2);
		if (noisy && $urandom_range(0, 1)) begin
			send_char($urandom_range(0, 1) ? hrl_pkg::CHAR_COLON : junk_char());
		end
		send_hex(ofs, 4);
		send_hex({8'h00, rtype}, 2);
		for (int k = 0; k < len; k++) begin
			b = 8'($urandom_range(0, 255));
			sum += b;
			send_hex({8'h00, b}, 2);
			if (noisy && $urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: send_char(hrl_pkg::CHAR_COLON);
					1: send_char(hrl_pkg::CHAR_CR);
					2: send_char(hrl_pkg::CHAR_LF);
					default: send_char(junk_char());
				endcase
			end
		end
		send_hex({8'h00, bad_sum ? 8'($urandom_range(0, 255)) : 8'(-sum)}, 2);
		if ($urandom_range(0, 3) != 0) begin
			send_char(hrl_pkg::CHAR_CR);
			send_char(hrl_pkg::CHAR_LF);
		end
	endtask

	task automatic test_stray_chars();
		// outside a record: extremes, line breaks, a stray digit, a non-hex letter
		send_char(8'h00);
		send_char(8'hFF);
		send_char(hrl_pkg::CHAR_CR);
		send_char(hrl_pkg::CHAR_LF);
		send_char(hrl_pkg::CHAR_0 + 8'd7);
		send_char(8'h67);
	endtask

	task automatic test_eof_record();
		// zero length, top offset, end-of-file type
		send_record(8'h00, 16'hFFFF, hrl_pkg::TYPE_EOF, 1'b0, 1'b0);
	endtask

	task automatic test_broken_record();
		// junk and a second colon mid-record must not consume digits
		send_char(hrl_pkg::CHAR_COLON);
		send_hex(16'h0001, 2);
		send_char(8'h5A);
		send_char(hrl_pkg::CHAR_COLON);
		send_hex(16'h0000, 4);
		send_char(8'hFF);
		send_hex(16'h0000, 2);
		send_hex(16'h00A5, 2);
		send_hex(16'h005A, 2);
	endtask

	// Mostly well-formed records with random content; some noisy, truncated or junk bursts.
	task automatic test_random_stream(input int until_count);
		int         pick;
		logic [7:0] len;
		logic [7:0] rtype;
		while (sent_count < until_count) begin
			if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				pick = $urandom_range(0, 99);
				if (pick < 2 && big_records_left > 0) begin
					len = 8'hFF;
					big_records_left--;
				end else if (pick < 12) begin
					len = 8'h00;
				end else begin
					len = 8'($urandom_range(1, 16));
				end
				pick = $urandom_range(0, 9);
				rtype = (pick < 5) ? 8'h00 : (pick < 7) ? hrl_pkg::TYPE_EOF :
					(pick < 9) ? 8'($urandom_range(2, 5)) : 8'($urandom_range(0, 255));
				send_record(len, 16'($urandom_range(0, 16'hFFFF)), rtype,
					$urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
			end else if (pick < 90) begin
				// truncated record: leaves the lexer mid-field
				send_char(hrl_pkg::CHAR_COLON);
				repeat ($urandom_range(1, 9)) begin
					send_char(digit_char(4'($urandom_range(0, 15)), 1'b1));
				end
			end else begin
				repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic test_drain_pause();
		// hold the sender until every queued result is out
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Result checker and random output stall.
	always @(posedge clk) begin : token_check
		token_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t: result with none expected, expected none, actual tdata %h tuser %h",
					$time, m_axis_tdata, m_axis_tuser);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				check_field("status", {15'h0, want.status}, {15'h0, m_axis_tdata[0]});
				check_field("token_valid", {15'h0, want.tok_valid}, {15'h0, m_axis_tdata[1]});
				check_field("token_kind", {13'h0, want.kind}, {13'h0, m_axis_tuser});
				check_field("token_value", want.value, m_axis_tdata[17:2]);
				check_field("end_of_file_seen", {15'h0, want.eof}, {15'h0, m_axis_tdata[18]});
			end
			rx_hold = no_gaps ? 0 : $urandom_range(0, 3);
		end else if (rx_hold > 0) begin
			rx_hold--;
		end
		m_axis_tready <= (rx_hold == 0);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_stray_chars();
		test_eof_record();
		test_broken_record();
		test_random_stream(ITEM_TARGET / 2);
		test_drain_pause();
		test_random_stream(ITEM_TARGET);
		s_axis_tvalid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/hrl_pkg.sv
design/hex_record_lexer.sv
tb/hex_record_lexer_tb.sv
